/* hdl/mfs_pkg.sv */
package mfs_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF   = 16;
    localparam int unsigned CFG_IDX_W       = 3;

    // internal working width: values saturate at +-(2^62-1)
    localparam int unsigned IW = 64;
    localparam logic signed [IW-1:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [IW+1:0] LIM66 = {{2{LIM[IW-1]}}, LIM};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INV_RE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DY = 3'd6;

    typedef logic signed [IW-1:0] t_val;

    typedef struct packed {
        t_val v;
        logic c;
    } t_sv;

    // clamp a 66-bit sum to +-LIM
    function automatic t_sv clamp66(input logic signed [IW+1:0] x);
        t_sv r;
        r.c = 1'b0;
        r.v = x[IW-1:0];
        if (x > LIM66) begin
            r.v = LIM;
            r.c = 1'b1;
        end else if (x < -LIM66) begin
            r.v = -LIM;
            r.c = 1'b1;
        end
        return r;
    endfunction

    function automatic t_sv sadd(input t_val a, input t_val b);
        return clamp66({{2{a[IW-1]}}, a} + {{2{b[IW-1]}}, b});
    endfunction

    function automatic t_sv ssub(input t_val a, input t_val b);
        return clamp66({{2{a[IW-1]}}, a} - {{2{b[IW-1]}}, b});
    endfunction

    function automatic t_val sabs(input t_val a);
        return a[IW-1] ? -a : a;
    endfunction

    // magnitude of a value known to lie in +-LIM
    function automatic logic [IW-3:0] mag(input t_val a);
        t_val m;
        m = a[IW-1] ? -a : a;
        return m[IW-3:0];
    endfunction

    // round the 126-bit product magnitude right by s, ties away, saturate, sign
    function automatic t_sv rnd(input logic [2*IW-3:0] pm, input logic neg,
                                input int unsigned s);
        logic [2*IW-2:0] q;
        t_sv r;
        q = ({1'b0, pm} + ((2*IW-1)'(1) << (s - 1))) >> s;
        r.c = 1'b0;
        if (q > (2*IW-1)'(LIM)) begin
            q = (2*IW-1)'(LIM);
            r.c = 1'b1;
        end
        r.v = neg ? -t_val'(q[IW-1:0]) : t_val'(q[IW-1:0]);
        return r;
    endfunction

endpackage

/* hdl/momentum_fg_stencil.sv */
// momentum_fg_stencil: one F (mode 0) or G (mode 1) value of the staggered
// grid momentum step, Q16.16, donor-cell blended convection.
// Input: start with mode, at_boundary and nine stencil samples; taken at
// each edge with i_start high and o_busy low. o_busy is always low: a new
// cell can be transferred every cycle with no dependence between cells.
// Output: o_done strobes for one cycle with o_result_value and o_saturated.
// The receiver cannot stall, so nothing holds the pipeline.
// Throughput one cell per cycle. Each pipeline step is one add level or one
// half of a 62x62 multiply (31-bit partial products, then sum and round).
// Configuration: i_cfg_valid/o_cfg_ready with index and data; always ready;
// write only while no cell is in flight. Unknown indexes are ignored.
// Reset: synchronous, active low, clears valid bits and loads register
// defaults. Boundary cells return the centre sample with o_saturated low.
module momentum_fg_stencil import mfs_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_mode,
    input  logic                          i_at_boundary,
    input  logic signed [VALUE_WIDTH-1:0] i_centre,
    input  logic signed [VALUE_WIDTH-1:0] i_prev_own,
    input  logic signed [VALUE_WIDTH-1:0] i_next_own,
    input  logic signed [VALUE_WIDTH-1:0] i_prev_other,
    input  logic signed [VALUE_WIDTH-1:0] i_next_other,
    input  logic signed [VALUE_WIDTH-1:0] i_cross_here,
    input  logic signed [VALUE_WIDTH-1:0] i_cross_along,
    input  logic signed [VALUE_WIDTH-1:0] i_cross_back,
    input  logic signed [VALUE_WIDTH-1:0] i_cross_back_along,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_done,
    output logic signed [VALUE_WIDTH-1:0] o_result_value,
    output logic                          o_saturated
);
    localparam int unsigned LAT = 22;

    // configuration registers
    logic signed [31:0] r_inv_re, r_grav_x, r_grav_y;
    logic [16:0]        r_alpha;
    logic [30:0]        r_dt, r_inv_dx, r_inv_dy;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_re <= 32'sd65536;
            r_grav_x <= '0;
            r_grav_y <= '0;
            r_alpha  <= 17'd58982;
            r_dt     <= 31'd3277;
            r_inv_dx <= 31'd65536;
            r_inv_dy <= 31'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INV_RE: r_inv_re <= i_cfg_data;
                REG_GRAV_X: r_grav_x <= i_cfg_data;
                REG_GRAV_Y: r_grav_y <= i_cfg_data;
                REG_ALPHA:  r_alpha  <= i_cfg_data[16:0];
                REG_DT:     r_dt     <= i_cfg_data[30:0];
                REG_INV_DX: r_inv_dx <= i_cfg_data[30:0];
                REG_INV_DY: r_inv_dy <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // valid bits and side data through the pipe
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_bnd;
    logic signed [VALUE_WIDTH-1:0] r_craw [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bnd    <= {r_bnd[LAT-2:0], i_at_boundary};
        r_craw[0] <= i_centre;
        for (int k = 1; k < LAT; k++) r_craw[k] <= r_craw[k-1];
    end

    // input widening with clamp to +-LIM
    localparam logic signed [IW+VALUE_WIDTH-1:0] LIMW = {{VALUE_WIDTH{1'b0}}, LIM};

    function automatic t_sv widen(input logic signed [VALUE_WIDTH-1:0] x);
        t_sv r;
        logic signed [IW+VALUE_WIDTH-1:0] w;
        w = {{IW{x[VALUE_WIDTH-1]}}, x};
        r.c = 1'b0;
        r.v = w[IW-1:0];
        if (w > LIMW) begin
            r.v = LIM;
            r.c = 1'b1;
        end else if (w < -LIMW) begin
            r.v = -LIM;
            r.c = 1'b1;
        end
        return r;
    endfunction

    // stage 1: widen samples, select axis constants
    t_sv r1_c, r1_p, r1_n, r1_po, r1_no, r1_ch, r1_ca, r1_cb, r1_cba;
    t_val r1_io, r1_it, r1_g;
    always_ff @(posedge i_clk) begin
        r1_c   <= widen(i_centre);
        r1_p   <= widen(i_prev_own);
        r1_n   <= widen(i_next_own);
        r1_po  <= widen(i_prev_other);
        r1_no  <= widen(i_next_other);
        r1_ch  <= widen(i_cross_here);
        r1_ca  <= widen(i_cross_along);
        r1_cb  <= widen(i_cross_back);
        r1_cba <= widen(i_cross_back_along);
        r1_io  <= t_val'(i_mode ? r_inv_dy : r_inv_dx);
        r1_it  <= t_val'(i_mode ? r_inv_dx : r_inv_dy);
        r1_g   <= t_val'(i_mode ? r_grav_y : r_grav_x);
    end

    // stage 2: first-level sums
    t_sv r2_sn, r2_sp, r2_dn, r2_dp, r2_sx, r2_sb, r2_sno, r2_spo, r2_dno, r2_dpo;
    t_sv r2_lo1, r2_lt1;
    t_val r2_c;
    logic r2_cl;
    t_val r2_io, r2_it, r2_g;
    always_ff @(posedge i_clk) begin
        r2_sn  <= sadd(r1_c.v, r1_n.v);
        r2_sp  <= sadd(r1_p.v, r1_c.v);
        r2_dn  <= ssub(r1_c.v, r1_n.v);
        r2_dp  <= ssub(r1_p.v, r1_c.v);
        r2_sx  <= sadd(r1_ch.v, r1_ca.v);
        r2_sb  <= sadd(r1_cb.v, r1_cba.v);
        r2_sno <= sadd(r1_no.v, r1_c.v);
        r2_spo <= sadd(r1_c.v, r1_po.v);
        r2_dno <= ssub(r1_c.v, r1_no.v);
        r2_dpo <= ssub(r1_po.v, r1_c.v);
        r2_lo1 <= sadd(r1_n.v, r1_p.v);
        r2_lt1 <= sadd(r1_no.v, r1_po.v);
        r2_c   <= r1_c.v;
        r2_cl  <= r1_c.c | r1_p.c | r1_n.c | r1_po.c | r1_no.c
                | r1_ch.c | r1_ca.c | r1_cb.c | r1_cba.c;
        r2_io  <= r1_io;
        r2_it  <= r1_it;
        r2_g   <= r1_g;
    end

    // stage 3: laplacian differences step
    t_sv w3_lo, w3_lt;
    t_sv r3_lo, r3_lt;
    logic r3_cl;
    assign w3_lo = ssub(r2_lo1.v, r2_c);
    assign w3_lt = ssub(r2_lt1.v, r2_c);
    always_ff @(posedge i_clk) begin
        r3_lo <= w3_lo;
        r3_lt <= w3_lt;
        r3_cl <= r2_cl | r2_sn.c | r2_sp.c | r2_dn.c | r2_dp.c | r2_sx.c | r2_sb.c
               | r2_sno.c | r2_spo.c | r2_dno.c | r2_dpo.c | r2_lo1.c | r2_lt1.c;
    end

    // multiply level A (stages 3..4): convective products, io^2, it^2
    t_sv m_a1, m_a2, m_b1, m_b2, m_c1, m_c2, m_d1, m_d2, m_ii, m_tt;
    mfs_mul #(.SHIFT(FRAC_BITS)) u_a1 (.i_clk, .i_a(r2_sn.v), .i_b(r2_sn.v), .o_p(m_a1));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_a2 (.i_clk, .i_a(r2_sp.v), .i_b(r2_sp.v), .o_p(m_a2));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_b1 (.i_clk, .i_a(sabs(r2_sn.v)), .i_b(r2_dn.v),
                                       .o_p(m_b1));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_b2 (.i_clk, .i_a(sabs(r2_sp.v)), .i_b(r2_dp.v),
                                       .o_p(m_b2));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_c1 (.i_clk, .i_a(r2_sno.v), .i_b(r2_sx.v), .o_p(m_c1));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_c2 (.i_clk, .i_a(r2_spo.v), .i_b(r2_sb.v), .o_p(m_c2));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_d1 (.i_clk, .i_a(sabs(r2_sx.v)), .i_b(r2_dno.v),
                                       .o_p(m_d1));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_d2 (.i_clk, .i_a(sabs(r2_sb.v)), .i_b(r2_dpo.v),
                                       .o_p(m_d2));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_ii (.i_clk, .i_a(r2_io), .i_b(r2_io), .o_p(m_ii));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_tt (.i_clk, .i_a(r2_it), .i_b(r2_it), .o_p(m_tt));

    // delay side values to the end of level A (stage 4)
    t_val r4_c, r4_io, r4_it, r4_g;
    t_sv  r4_lo, r4_lt;
    logic r4_cl;
    t_val r3_c, r3_io, r3_it, r3_g;
    always_ff @(posedge i_clk) begin
        r3_c  <= r2_c;   r3_io <= r2_io;  r3_it <= r2_it;  r3_g <= r2_g;
        r4_c  <= r3_c;   r4_io <= r3_io;  r4_it <= r3_it;  r4_g <= r3_g;
        r4_lo <= ssub(r3_lo.v, r3_c);
        r4_lt <= ssub(r3_lt.v, r3_c);
        r4_cl <= r3_cl | r3_lo.c | r3_lt.c;
    end

    // stage 5: differences of products
    t_sv r5_t1o, r5_t2o, r5_t1t, r5_t2t;
    t_sv r5_ii, r5_tt, r5_lo, r5_lt;
    t_val r5_c, r5_io, r5_it, r5_g;
    logic r5_cl;
    always_ff @(posedge i_clk) begin
        r5_t1o <= ssub(m_a1.v, m_a2.v);
        r5_t2o <= ssub(m_b1.v, m_b2.v);
        r5_t1t <= ssub(m_c1.v, m_c2.v);
        r5_t2t <= ssub(m_d1.v, m_d2.v);
        r5_ii  <= m_ii;  r5_tt <= m_tt;
        r5_lo  <= r4_lo; r5_lt <= r4_lt;
        r5_c   <= r4_c;  r5_io <= r4_io; r5_it <= r4_it; r5_g <= r4_g;
        r5_cl  <= r4_cl | r4_lo.c | r4_lt.c | m_a1.c | m_a2.c | m_b1.c | m_b2.c
                | m_c1.c | m_c2.c | m_d1.c | m_d2.c | m_ii.c | m_tt.c;
    end

    // multiply level B (stages 6..7): alpha terms, laplacian terms
    t_val w_al;
    assign w_al = t_val'(r_alpha);
    t_sv m_ao, m_at, m_lo, m_lt;
    mfs_mul #(.SHIFT(FRAC_BITS)) u_ao (.i_clk, .i_a(w_al), .i_b(r5_t2o.v), .o_p(m_ao));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_at (.i_clk, .i_a(w_al), .i_b(r5_t2t.v), .o_p(m_at));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_lo (.i_clk, .i_a(r5_ii.v), .i_b(r5_lo.v), .o_p(m_lo));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_lt (.i_clk, .i_a(r5_tt.v), .i_b(r5_lt.v), .o_p(m_lt));

    t_val r6_c, r6_io, r6_it, r6_g, r6_t1o, r6_t1t;
    t_val r7_c, r7_io, r7_it, r7_g, r7_t1o, r7_t1t;
    logic r6_cl, r7_cl;
    always_ff @(posedge i_clk) begin
        r6_c <= r5_c; r6_io <= r5_io; r6_it <= r5_it; r6_g <= r5_g;
        r6_t1o <= r5_t1o.v; r6_t1t <= r5_t1t.v;
        r6_cl <= r5_cl | r5_t1o.c | r5_t2o.c | r5_t1t.c | r5_t2t.c;
        r7_c <= r6_c; r7_io <= r6_io; r7_it <= r6_it; r7_g <= r6_g;
        r7_t1o <= r6_t1o; r7_t1t <= r6_t1t; r7_cl <= r6_cl;
    end

    // stage 8: blended sums and laplacian
    t_sv r8_so, r8_st, r8_lap;
    t_val r8_c, r8_io, r8_it, r8_g;
    logic r8_cl;
    always_ff @(posedge i_clk) begin
        r8_so  <= sadd(r7_t1o, m_ao.v);
        r8_st  <= sadd(r7_t1t, m_at.v);
        r8_lap <= sadd(m_lo.v, m_lt.v);
        r8_c <= r7_c; r8_io <= r7_io; r8_it <= r7_it; r8_g <= r7_g;
        r8_cl <= r7_cl | m_ao.c | m_at.c | m_lo.c | m_lt.c;
    end

    // multiply level C (stages 9..10): quarter products and viscous term
    t_sv m_do, m_dt, m_vs;
    mfs_mul #(.SHIFT(FRAC_BITS + 2)) u_do (.i_clk, .i_a(r8_io), .i_b(r8_so.v), .o_p(m_do));
    mfs_mul #(.SHIFT(FRAC_BITS + 2)) u_dt (.i_clk, .i_a(r8_it), .i_b(r8_st.v), .o_p(m_dt));
    mfs_mul #(.SHIFT(FRAC_BITS)) u_vs (.i_clk, .i_a(t_val'(r_inv_re)), .i_b(r8_lap.v),
                                       .o_p(m_vs));

    t_val r9_c, r9_g, r10_c, r10_g;
    logic r9_cl, r10_cl;
    always_ff @(posedge i_clk) begin
        r9_c <= r8_c; r9_g <= r8_g;
        r9_cl <= r8_cl | r8_so.c | r8_st.c | r8_lap.c;
        r10_c <= r9_c; r10_g <= r9_g; r10_cl <= r9_cl;
    end

    // stages 11..13: rhs = vis - d_own - d_oth + g
    t_sv r11_a, r12_a, r13_a;
    t_val r11_d, r11_c, r11_g, r12_c, r12_g, r13_c;
    logic r11_cl, r12_cl, r13_cl;
    always_ff @(posedge i_clk) begin
        r11_a <= ssub(m_vs.v, m_do.v);
        r11_d <= m_dt.v;
        r11_c <= r10_c; r11_g <= r10_g;
        r11_cl <= r10_cl | m_vs.c | m_do.c | m_dt.c;
        r12_a <= ssub(r11_a.v, r11_d);
        r12_c <= r11_c; r12_g <= r11_g; r12_cl <= r11_cl | r11_a.c;
        r13_a <= sadd(r12_a.v, r12_g);
        r13_c <= r12_c; r13_cl <= r12_cl | r12_a.c;
    end

    // multiply level D (stages 14..15): dt * rhs
    t_sv m_st;
    mfs_mul #(.SHIFT(FRAC_BITS)) u_st (.i_clk, .i_a(t_val'(r_dt)), .i_b(r13_a.v),
                                       .o_p(m_st));
    t_val r14_c, r15_c;
    logic r14_cl, r15_cl;
    always_ff @(posedge i_clk) begin
        r14_c <= r13_c; r14_cl <= r13_cl | r13_a.c;
        r15_c <= r14_c; r15_cl <= r14_cl;
    end

    // stage 16: final add; stage 17: clip to output width
    t_sv r16_r;
    logic r16_cl;
    localparam logic signed [IW-1:0] OHI = t_val'((65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1);
    localparam logic signed [IW-1:0] OLO = -OHI - t_val'(1);
    logic signed [VALUE_WIDTH-1:0] r17_v;
    logic r17_cl;
    always_ff @(posedge i_clk) begin
        r16_r  <= sadd(r15_c, m_st.v);
        r16_cl <= r15_cl | m_st.c;
        if (r16_r.v > OHI) begin
            r17_v  <= OHI[VALUE_WIDTH-1:0];
            r17_cl <= 1'b1;
        end else if (r16_r.v < OLO) begin
            r17_v  <= OLO[VALUE_WIDTH-1:0];
            r17_cl <= 1'b1;
        end else begin
            r17_v  <= r16_r.v[VALUE_WIDTH-1:0];
            r17_cl <= r16_cl | r16_r.c;
        end
    end

    // align stage 17 with the delay line; pad to LAT with output stages
    localparam int unsigned CORE = 17;
    localparam int unsigned PAD  = LAT - CORE;
    logic signed [VALUE_WIDTH-1:0] r_pv [PAD];
    logic [PAD-1:0] r_pc;
    always_ff @(posedge i_clk) begin
        r_pv[0] <= r17_v;
        r_pc[0] <= r17_cl;
        for (int k = 1; k < PAD; k++) begin
            r_pv[k] <= r_pv[k-1];
            r_pc[k] <= r_pc[k-1];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_vld[LAT-2];
        end
        if (r_bnd[LAT-2]) begin
            o_result_value <= r_craw[LAT-2];
            o_saturated    <= 1'b0;
        end else begin
            o_result_value <= r_pv[PAD-2];
            o_saturated    <= r_pc[PAD-2];
        end
    end

    logic w_unused;
    assign w_unused = ^{r_bnd[LAT-1], r_craw[LAT-1], r_pv[PAD-1], r_pc[PAD-1],
                        r_vld[LAT-1]};

`ifndef SYNTH
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_vld[LAT-2])) else $error("strobe without valid");
    a_bnd_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(r_bnd[LAT-2])) |-> !o_saturated)
        else $error("boundary flagged");
    a_never_busy: assert property (@(posedge i_clk) !o_busy) else $error("busy");
`endif
endmodule

/* hdl/mfs_mul.sv */
// Registered signed fixed-point multiply: 62x62 magnitude product cut into
// 31-bit partial products in the first of two stages, then sum, round and saturate in the second.
module mfs_mul import mfs_pkg::*; #(
    parameter int unsigned SHIFT = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  t_val i_a,
    input  t_val i_b,
    output t_sv  o_p
);
    localparam int unsigned H = (IW - 2) / 2;

    logic [IW-3:0]     w_ma, w_mb;
    logic [2*H-1:0]    r_p00, r_p01, r_p10, r_p11;
    logic              r_neg;
    logic [2*IW-3:0]   w_sum;

    assign w_ma = mag(i_a);
    assign w_mb = mag(i_b);

    // partial products
    always_ff @(posedge i_clk) begin
        r_p00 <= w_ma[H-1:0]  * w_mb[H-1:0];
        r_p01 <= w_ma[H-1:0]  * w_mb[2*H-1:H];
        r_p10 <= w_ma[2*H-1:H] * w_mb[H-1:0];
        r_p11 <= w_ma[2*H-1:H] * w_mb[2*H-1:H];
        r_neg <= i_a[IW-1] ^ i_b[IW-1];
    end

    assign w_sum = (2*IW-2)'(r_p00) + ((2*IW-2)'(r_p01) << H)
                 + ((2*IW-2)'(r_p10) << H) + ((2*IW-2)'(r_p11) << (2*H));

    // round and saturate
    always_ff @(posedge i_clk) begin
        o_p <= rnd(w_sum, r_neg, SHIFT);
    end
endmodule

/* tb/sv/testbench.sv */
module testbench;
    import mfs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam int SMALL_SPAN = 32'h0004_0000;

    typedef struct {
        logic                     mode;
        logic                     bnd;
        logic signed [31:0]       s [9];
    } cell_t;

    typedef struct {
        logic signed [31:0] value;
        logic               sat;
    } fg_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic i_mode = 1'b0;
    logic i_at_boundary = 1'b0;
    logic signed [31:0] smp [9] = '{default: '0};
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_busy, o_cfg_ready, o_done, o_saturated;
    logic signed [31:0] o_result_value;

    // mirror of the configuration registers
    longint re_coef, grav_x, grav_y, alpha, dt, inv_dx, inv_dy;
    logic clip_flag;
    fg_t pending_fg [$];
    int errors = 0;

    momentum_fg_stencil DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_mode(i_mode), .i_at_boundary(i_at_boundary),
        .i_centre(smp[0]), .i_prev_own(smp[1]), .i_next_own(smp[2]),
        .i_prev_other(smp[3]), .i_next_other(smp[4]), .i_cross_here(smp[5]),
        .i_cross_along(smp[6]), .i_cross_back(smp[7]), .i_cross_back_along(smp[8]),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_result_value(o_result_value), .o_saturated(o_saturated)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAIL momentum_fg_stencil");
        $finish;
    end

    // saturating arithmetic at the internal 62-bit range
    function automatic longint clp(input logic signed [65:0] x);
        if (x > SAT_LIM) begin
            clip_flag = 1'b1;
            return SAT_LIM;
        end
        if (x < -SAT_LIM) begin
            clip_flag = 1'b1;
            return -SAT_LIM;
        end
        return longint'(x);
    endfunction

    function automatic longint s_add(input longint a, input longint b);
        logic signed [65:0] x;
        x = 66'(a) + 66'(b);
        return clp(x);
    endfunction

    function automatic longint s_sub(input longint a, input longint b);
        logic signed [65:0] x;
        x = 66'(a) - 66'(b);
        return clp(x);
    endfunction

    function automatic longint s_abs(input longint a);
        return a < 0 ? -a : a;
    endfunction

    // rounded (ties away) and saturated product shifted right by sh
    function automatic longint mul_sh(input longint a, input longint b, input int sh);
        logic [127:0] ma, mb, q;
        ma = {64'd0, 64'(s_abs(a))};
        mb = {64'd0, 64'(s_abs(b))};
        q = ((ma * mb) + (128'd1 << (sh - 1))) >> sh;
        if (q > 128'(SAT_LIM)) begin
            clip_flag = 1'b1;
            q = 128'(SAT_LIM);
        end
        return ((a < 0) != (b < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint mq(input longint a, input longint b);
        return mul_sh(a, b, 16);
    endfunction

    function automatic fg_t predict_fg(input cell_t cl);
        longint c, p, n, po, no, ch, ca, cb, cba, io, it, g;
        longint sn, sp, sx, sb, t1, t2, d_own, d_oth, lap, rhs, res;
        fg_t r;
        clip_flag = 1'b0;
        if (cl.bnd) begin
            r.value = cl.s[0];
            r.sat = 1'b0;
            return r;
        end
        c = longint'(cl.s[0]); p = longint'(cl.s[1]); n = longint'(cl.s[2]);
        po = longint'(cl.s[3]); no = longint'(cl.s[4]); ch = longint'(cl.s[5]);
        ca = longint'(cl.s[6]); cb = longint'(cl.s[7]); cba = longint'(cl.s[8]);
        io = cl.mode ? inv_dy : inv_dx;
        it = cl.mode ? inv_dx : inv_dy;
        g = cl.mode ? grav_y : grav_x;
        // own-axis convection
        sn = s_add(c, n);
        sp = s_add(p, c);
        t1 = s_sub(mq(sn, sn), mq(sp, sp));
        t2 = s_sub(mq(s_abs(sn), s_sub(c, n)), mq(s_abs(sp), s_sub(p, c)));
        d_own = mul_sh(io, s_add(t1, mq(alpha, t2)), 18);
        // cross-axis convection of the product
        sx = s_add(ch, ca);
        sb = s_add(cb, cba);
        t1 = s_sub(mq(s_add(no, c), sx), mq(s_add(c, po), sb));
        t2 = s_sub(mq(s_abs(sx), s_sub(c, no)), mq(s_abs(sb), s_sub(po, c)));
        d_oth = mul_sh(it, s_add(t1, mq(alpha, t2)), 18);
        // diffusion
        lap = s_add(mq(mq(io, io), s_sub(s_sub(s_add(n, p), c), c)),
                    mq(mq(it, it), s_sub(s_sub(s_add(no, po), c), c)));
        rhs = s_add(s_sub(s_sub(mq(re_coef, lap), d_own), d_oth), g);
        res = s_add(c, mq(dt, rhs));
        if (res > 64'sh7FFF_FFFF) begin
            res = 64'sh7FFF_FFFF;
            clip_flag = 1'b1;
        end
        if (res < -64'sh8000_0000) begin
            res = -64'sh8000_0000;
            clip_flag = 1'b1;
        end
        r.value = res[31:0];
        r.sat = clip_flag;
        return r;
    endfunction

    function automatic void mirror_reset();
        re_coef = 65536; grav_x = 0; grav_y = 0; alpha = 58982;
        dt = 3277; inv_dx = 65536; inv_dy = 65536;
    endfunction

    function automatic void mirror_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [31:0] d);
        case (idx)
            REG_INV_RE: re_coef = longint'(signed'(d));
            REG_GRAV_X: grav_x = longint'(signed'(d));
            REG_GRAV_Y: grav_y = longint'(signed'(d));
            REG_ALPHA:  alpha = longint'(d[16:0]);
            REG_DT:     dt = longint'(d[30:0]);
            REG_INV_DX: inv_dx = longint'(d[30:0]);
            REG_INV_DY: inv_dy = longint'(d[30:0]);
            default: ;
        endcase
    endfunction

    // result checker: every strobe pops the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_fg.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", o_result_value);
            end else begin
                fg_t e;
                e = pending_fg.pop_front();
                if (e.value !== o_result_value || e.sat !== o_saturated) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %h sat %b, got %h sat %b",
                                 e.value, e.sat, o_result_value, o_saturated);
                end
            end
        end
    end

    // called at a rising edge; returns at the transfer edge
    task automatic send_cell(input cell_t cl);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_mode <= cl.mode;
        i_at_boundary <= cl.bnd;
        for (int k = 0; k < 9; k++) smp[k] <= cl.s[k];
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_fg.push_back(predict_fg(cl));
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_fg.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mirror_write(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_sample(input bit wide);
        if (wide) return $urandom;
        return $signed($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
    endfunction

    function automatic cell_t rand_cell(input bit wide);
        cell_t cl;
        cl.mode = 1'($urandom_range(0, 1));
        cl.bnd = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < 9; k++) cl.s[k] = rand_sample(wide);
        return cl;
    endfunction

    function automatic cell_t fill_cell(input logic m, input logic b,
                                        input logic signed [31:0] v);
        cell_t cl;
        cl.mode = m;
        cl.bnd = b;
        for (int k = 0; k < 9; k++) cl.s[k] = v;
        return cl;
    endfunction

    // extremes, boundary copies, both modes
    task automatic test_directed();
        cell_t cl;
        logic md;
        for (int m = 0; m < 2; m++) begin
            md = 1'(m);
            send_cell(fill_cell(md, 1'b0, 32'sd0));
            send_cell(fill_cell(md, 1'b0, 32'sh7FFF_FFFF));
            send_cell(fill_cell(md, 1'b0, 32'sh8000_0000));
            send_cell(fill_cell(md, 1'b1, 32'sh7FFF_FFFF));
            send_cell(fill_cell(md, 1'b1, 32'sh8000_0000));
            send_cell(fill_cell(md, 1'b0, 32'sh0001_0000));
            // alternating extremes, first as an interior and then as a boundary cell
            cl = fill_cell(md, 1'b0, 32'sh7FFF_FFFF);
            for (int k = 1; k < 9; k += 2) cl.s[k] = 32'sh8000_0000;
            send_cell(cl);
            cl.bnd = 1'b1;
            send_cell(cl);
            cl = fill_cell(md, 1'b0, 32'sh0002_0000);
            cl.s[2] = -32'sh0001_0000;
            cl.s[5] = -32'sh0003_0000;
            send_cell(cl);
        end
        drain();
    endtask

    // random content under one setting of every register
    task automatic run_phase(input logic [31:0] re, gx, gy, al, st, dx, dy, input int items);
        write_reg(REG_INV_RE, re);
        write_reg(REG_GRAV_X, gx);
        write_reg(REG_GRAV_Y, gy);
        write_reg(REG_ALPHA, al);
        write_reg(REG_DT, st);
        write_reg(REG_INV_DX, dx);
        write_reg(REG_INV_DY, dy);
        for (int k = 0; k < items; k++) send_cell(rand_cell($urandom_range(0, 4) == 0));
        drain();
    endtask

    task automatic test_config_sweep();
        run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 60);
        run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1_0000,
                  32'h0, 32'h0, 32'h7FFF_FFFF, 60);
        // weight above one, random registers with full data words
        run_phase($urandom, $urandom, $urandom, 32'hFFFF_FFFF,
                  $urandom, $urandom, $urandom, 60);
        run_phase(32'h0000_0CCD, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_E666,
                  32'h0000_1000, 32'h0002_0000, 32'h0000_8000, 80);
        // an unknown index must leave the mirror and the block unchanged
        write_reg(REG_UNUSED, $urandom);
        for (int k = 0; k < 20; k++) send_cell(rand_cell(1'b0));
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 8; ph++) begin
            run_phase($urandom_range(0, 32'h0002_0000), $signed($urandom_range(0, 32'h4_0000))
                      - 32'sh2_0000, $urandom, $urandom_range(0, 32'h1_0000),
                      $urandom_range(0, 32'h2_0000), $urandom_range(0, 32'h4_0000),
                      $urandom_range(0, 32'h4_0000), 140);
        end
    endtask

    initial begin
        mirror_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_random();
        drain();
        repeat (30) @(posedge i_clk);
        if (errors == 0 && pending_fg.size() == 0) begin
            $display("PASS momentum_fg_stencil");
        end else begin
            $display("FAIL momentum_fg_stencil");
        end
        $finish;
    end

endmodule

/* momentum_fg_stencil.f */
hdl/mfs_pkg.sv
hdl/mfs_mul.sv
hdl/momentum_fg_stencil.sv
tb/sv/testbench.sv
